>>> design/swpi_pkg.sv
// Package for the stack with positional insert: sizes, codes and the control
// struct passed from the action decoder to the word row.
// No dependencies.
package swpi_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 64;

  // Field widths fixed by the stream format
  localparam int ACT_W     = 2;
  localparam int ENTRY_W   = 64;
  localparam int POS_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_O_W = 7;
  localparam int TDATA_W   = ((ENTRY_W + POS_W + 7) / 8) * 8;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_INSERT = 2'd2
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] slot;        // row index of the new word, 0 is the top
    status_t          status;
    logic [CNT_W-1:0] count_next;
  } ctl_t;

endpackage

>>> design/stack_with_positional_insert.sv
// Stack with positional insert: input register, decode and row update, result register.
// Accepted beats wait in the input register, results in the result register on m_axis.
// One beat per cycle unless m_axis stalls; each action updates every row word at once.
// Reset clears the fill count and both valid flags; stored words stay undefined.
// Depends on swpi_pkg, swpi_decode and swpi_row.
module stack_with_positional_insert (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [swpi_pkg::TDATA_W-1:0]   s_axis_tdata,  // entry_data, position
  input  logic [swpi_pkg::ACT_W-1:0]     s_axis_tuser,  // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [swpi_pkg::TDATA_W-1:0]   m_axis_tdata,  // popped_data, depth_count
  output logic [swpi_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);
  import swpi_pkg::*;

  logic                  in_valid;
  logic [ACT_W-1:0]      in_act;
  logic [DATA_WIDTH-1:0] in_data;
  logic [POS_W-1:0]      in_pos;

  logic [CNT_W-1:0]      count;

  logic                  out_valid;
  status_t               out_status;
  logic [ENTRY_W-1:0]    out_popped;
  logic [DEPTH_O_W-1:0]  out_depth;

  logic                  advance;
  ctl_t                  ctl;
  logic [DATA_WIDTH-1:0] top_data;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  swpi_decode u_decode (
    .act   (in_act),
    .pos   (in_pos),
    .count (count),
    .ctl   (ctl)
  );

  swpi_row u_row (
    .clk      (clk),
    .en       (advance),
    .ctl      (ctl),
    .wr_data  (in_data),
    .top_data (top_data)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_act  <= s_axis_tuser;
      in_data <= s_axis_tdata[DATA_WIDTH-1:0];
      in_pos  <= s_axis_tdata[ENTRY_W +: POS_W];
    end
  end

  // Fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        count     <= ctl.count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_status <= ctl.status;
      out_depth  <= DEPTH_O_W'(ctl.count_next);
      out_popped <= (ctl.op == OP_POP) ? ENTRY_W'(top_data) : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {{(TDATA_W - ENTRY_W - DEPTH_O_W){1'b0}}, out_depth, out_popped};

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_reject_holds : assert property (@(posedge clk) disable iff (rst)
    advance && ctl.status != ST_OK |=> $stable(count))
    else $error("rejected action changed the fill count");

  a_empty_result : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_EMPTY |-> out_depth == '0 && out_popped == '0)
    else $error("empty report with nonzero depth or data");

  a_full_result : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_FULL |-> out_depth == DEPTH_O_W'(DEPTH))
    else $error("full report below depth");

  a_count_tracks : assert property (@(posedge clk) disable iff (rst)
    advance |=> out_depth == DEPTH_O_W'(count))
    else $error("reported depth differs from fill count");

endmodule

>>> design/swpi_decode.sv
// Action decoder: checks an action against the current fill count and
// produces the row control, status and next count. Uses swpi_pkg.
module swpi_decode (
  input  logic [swpi_pkg::ACT_W-1:0] act,
  input  logic [swpi_pkg::POS_W-1:0] pos,
  input  logic [swpi_pkg::CNT_W-1:0] count,
  output swpi_pkg::ctl_t             ctl
);
  import swpi_pkg::*;

  logic             full;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] ins_slot;

  assign full     = (count == CNT_W'(DEPTH));
  assign pos_w    = CMP_W'(pos);
  assign cnt_w    = CMP_W'(count);
  // Row is held top first, so bottom position k lands at row count + 1 - k
  assign ins_slot = cnt_w + CMP_W'(1) - pos_w;

  always_comb begin
    ctl.op         = OP_HOLD;
    ctl.slot       = '0;
    ctl.status     = ST_OK;
    ctl.count_next = count;
    unique case (act_t'(act))
      ACT_PUSH: begin
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.op         = OP_INSERT;
          ctl.count_next = count + CNT_W'(1);
        end
      end
      ACT_POP: begin
        if (count == '0) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.op         = OP_POP;
          ctl.count_next = count - CNT_W'(1);
        end
      end
      ACT_INSERT: begin
        priority if (full) begin
          ctl.status = ST_FULL;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          ctl.status = ST_BADPOS;
        end else begin
          ctl.op         = OP_INSERT;
          ctl.slot       = ins_slot[IDX_W-1:0];
          ctl.count_next = count + CNT_W'(1);
        end
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
  end

endmodule

>>> design/swpi_row.sv
// Word row: DEPTH registers held top first, each with its own shift mux, so
// push, pop and insert all complete in one update. Uses swpi_pkg.
module swpi_row (
  input  logic                            clk,
  input  logic                            en,
  input  swpi_pkg::ctl_t                  ctl,
  input  logic [swpi_pkg::DATA_WIDTH-1:0] wr_data,
  output logic [swpi_pkg::DATA_WIDTH-1:0] top_data
);
  import swpi_pkg::*;

  logic [DATA_WIDTH-1:0] cells      [DEPTH];
  logic [DATA_WIDTH-1:0] cells_next [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] nearer;  // neighbour toward the top
    logic [DATA_WIDTH-1:0] deeper;  // neighbour toward the bottom

    if (g == 0) begin : g_first
      assign nearer = wr_data;
    end else begin : g_mid
      assign nearer = cells[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign deeper = cells[g];
    end else begin : g_inner
      assign deeper = cells[g+1];
    end

    always_comb begin
      cells_next[g] = cells[g];
      unique case (ctl.op)
        OP_INSERT: begin
          if (IDX_W'(g) == ctl.slot) begin
            cells_next[g] = wr_data;
          end else if (IDX_W'(g) > ctl.slot) begin
            cells_next[g] = nearer;
          end
        end
        OP_POP: begin
          cells_next[g] = deeper;
        end
        default: begin
          cells_next[g] = cells[g];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cells <= cells_next;
    end
  end

  assign top_data = cells[0];

endmodule
